// File: design/cpot_pkg.sv
// ----------------------------------------------------------------------------
// cpot_pkg
// Shared constants for the capsule pair overlap test: field widths, register
// reset value and the distance saturation limit.
// ----------------------------------------------------------------------------
package cpot_pkg;

    localparam int PT_BITS   = 60;
    localparam int RAD_BITS  = 16;
    localparam int THR_BITS  = 32;
    localparam int DIST_BITS = 47;
    localparam int IN_BITS   = 4 * PT_BITS + 2 * RAD_BITS;
    localparam int OUT_BITS  = DIST_BITS + 1;

    localparam logic [THR_BITS-1:0]  THR_RESET = 32'd281474977;
    localparam logic [DIST_BITS-1:0] DIST_MAX  = {DIST_BITS{1'b1}};

endpackage

// File: design/capsule_pair_overlap_test.sv
// ----------------------------------------------------------------------------
// capsule_pair_overlap_test
// Closest-point distance between two capsule segments and overlap flag.
// ----------------------------------------------------------------------------
// Fully pipelined: one capsule pair per cycle while the output is not
// stalled. The pipeline depth is set by the bit-per-stage divider for s and t
// plus the split wide multipliers for the cross products and squares. A stall on
// the output freezes the whole pipeline; nothing is dropped or repeated.
module capsule_pair_overlap_test
    import cpot_pkg::*;
#(
    parameter int COORD_BITS      = 20,
    parameter int PARAM_FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // first_start, first_end, second_start, second_end, first_radius,
    // second_radius
    input  logic [IN_BITS-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // overlap, distance_squared
    output logic [OUT_BITS-1:0] m_axis_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [THR_BITS-1:0] cfg_data
);

    localparam int N    = COORD_BITS;
    localparam int F    = PARAM_FRAC_BITS;
    localparam int DW   = N + 1;
    localparam int PW   = 2 * DW;
    localparam int DOTW = PW + 2;
    localparam int XW   = 2 * DOTW + 1;
    localparam int GW   = N + F + 4;
    localparam int SQW  = 2 * GW;
    localparam int SW   = SQW + 2;
    localparam int RSW  = 2 * (RAD_BITS + 1);
    localparam int PTW  = (PT_BITS > 3 * N) ? PT_BITS : 3 * N;
    localparam int MW   = (SW > DIST_BITS) ? SW : DIST_BITS;
    localparam int UVW  = 9 * DW;
    localparam int UVD  = F + 8;
    localparam int RQD  = F + 13;
    localparam int LAT  = F + 14;

    logic en;
    logic [THR_BITS-1:0] thr_reg;
    logic vld_reg [0:LAT-1];

    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // stage 0: differences, radius sum squared
    logic [PTW-1:0]        pe [0:3];
    logic signed [N-1:0]   ca0 [0:2], ca1 [0:2], cb0 [0:2], cb1 [0:2];
    logic [UVW-1:0]        uvw_next;
    logic [RAD_BITS:0]     rs;
    logic [RSW-1:0]        rsq_next;
    logic [UVW-1:0]        uvw_reg [0:UVD-1];
    logic [RSW-1:0]        rsq_reg [0:RQD-1];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            pe[i] = PTW'(s_axis_tdata[i*PT_BITS +: PT_BITS]);
        for (int a = 0; a < 3; a++)
        begin
            ca0[a] = $signed(pe[0][a*N +: N]);
            ca1[a] = $signed(pe[1][a*N +: N]);
            cb0[a] = $signed(pe[2][a*N +: N]);
            cb1[a] = $signed(pe[3][a*N +: N]);
            uvw_next[a*DW +: DW]     = DW'(ca1[a]) - DW'(ca0[a]);
            uvw_next[(3+a)*DW +: DW] = DW'(cb1[a]) - DW'(cb0[a]);
            uvw_next[(6+a)*DW +: DW] = DW'(ca0[a]) - DW'(cb0[a]);
        end
        rs = (RAD_BITS+1)'(s_axis_tdata[4*PT_BITS +: RAD_BITS])
           + (RAD_BITS+1)'(s_axis_tdata[4*PT_BITS+RAD_BITS +: RAD_BITS]);
        rsq_next = rs * rs;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            uvw_reg[0] <= uvw_next;
            for (int k = 1; k < UVD; k++)
                uvw_reg[k] <= uvw_reg[k-1];
            rsq_reg[0] <= rsq_next;
            for (int k = 1; k < RQD; k++)
                rsq_reg[k] <= rsq_reg[k-1];
        end
    end

    // stage 1: per-axis products (uu, uv, vv, uw, vw)
    logic signed [DW-1:0] pu [0:2], pv [0:2], pw [0:2];
    logic signed [PW-1:0] prod_next [0:14];
    logic signed [PW-1:0] prod_reg  [0:14];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            pu[a] = $signed(uvw_reg[0][a*DW +: DW]);
            pv[a] = $signed(uvw_reg[0][(3+a)*DW +: DW]);
            pw[a] = $signed(uvw_reg[0][(6+a)*DW +: DW]);
            prod_next[a]      = pu[a] * pu[a];
            prod_next[3 + a]  = pu[a] * pv[a];
            prod_next[6 + a]  = pv[a] * pv[a];
            prod_next[9 + a]  = pu[a] * pw[a];
            prod_next[12 + a] = pv[a] * pw[a];
        end
    end

    // stage 2: dot products
    logic signed [DOTW-1:0] dot_next [0:4];
    logic signed [DOTW-1:0] dot_reg  [0:4];

    always_comb
    begin
        for (int j = 0; j < 5; j++)
            dot_next[j] = DOTW'(prod_reg[3*j]) + DOTW'(prod_reg[3*j+1])
                        + DOTW'(prod_reg[3*j+2]);
    end

    logic [4*DOTW-1:0] dd_reg [0:1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            dot_reg  <= dot_next;
            dd_reg[0] <= {dot_reg[4], dot_reg[3], dot_reg[2], dot_reg[1]};
            dd_reg[1] <= dd_reg[0];
        end
    end

    // stages 3-4: cross products
    logic signed [2*DOTW-1:0] cp [0:5];

    cpot_smul #(.AW(DOTW), .BW(DOTW)) u_cp0
        (.clk(clk), .en(en), .a(dot_reg[0]), .b(dot_reg[2]), .p(cp[0]));
    cpot_smul #(.AW(DOTW), .BW(DOTW)) u_cp1
        (.clk(clk), .en(en), .a(dot_reg[1]), .b(dot_reg[1]), .p(cp[1]));
    cpot_smul #(.AW(DOTW), .BW(DOTW)) u_cp2
        (.clk(clk), .en(en), .a(dot_reg[1]), .b(dot_reg[4]), .p(cp[2]));
    cpot_smul #(.AW(DOTW), .BW(DOTW)) u_cp3
        (.clk(clk), .en(en), .a(dot_reg[2]), .b(dot_reg[3]), .p(cp[3]));
    cpot_smul #(.AW(DOTW), .BW(DOTW)) u_cp4
        (.clk(clk), .en(en), .a(dot_reg[0]), .b(dot_reg[4]), .p(cp[4]));
    cpot_smul #(.AW(DOTW), .BW(DOTW)) u_cp5
        (.clk(clk), .en(en), .a(dot_reg[1]), .b(dot_reg[3]), .p(cp[5]));

    // stage 5: denominator, numerators, near-parallel candidates
    logic signed [DOTW-1:0] d_uv, d_vv, d_uw, d_vw;
    logic [DOTW-1:0]        uv_abs;
    logic                   gt;
    logic signed [XW-1:0]   den_reg, snum_reg, tnum_reg, npn_reg;
    logic [XW-1:0]          npd_reg;

    always_comb
    begin
        d_uv   = $signed(dd_reg[1][0 +: DOTW]);
        d_vv   = $signed(dd_reg[1][DOTW +: DOTW]);
        d_uw   = $signed(dd_reg[1][2*DOTW +: DOTW]);
        d_vw   = $signed(dd_reg[1][3*DOTW +: DOTW]);
        uv_abs = d_uv[DOTW-1] ? (~d_uv + 1'b1) : d_uv;
        gt     = d_uv > d_vv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg  <= XW'(cp[0]) - XW'(cp[1]);
            snum_reg <= XW'(cp[2]) - XW'(cp[3]);
            tnum_reg <= XW'(cp[4]) - XW'(cp[5]);
            npn_reg  <= gt ? XW'(d_uw) : XW'(d_vw);
            npd_reg  <= gt ? XW'(uv_abs) : XW'($unsigned(d_vv));
        end
    end

    // stage 6: branch select
    logic                 deg;
    logic signed [XW-1:0] ns_reg, nt_reg;
    logic [XW-1:0]        ds_reg, dt_reg;

    assign deg = den_reg[XW-1] || ($unsigned(den_reg) < XW'(thr_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ns_reg <= deg ? '0 : snum_reg;
            ds_reg <= deg ? XW'(1) : $unsigned(den_reg);
            nt_reg <= deg ? npn_reg : tnum_reg;
            dt_reg <= deg ? npd_reg : $unsigned(den_reg);
        end
    end

    // stages 7 .. F+7: dividers
    logic [F:0] s_q, t_q;

    cpot_fdiv #(.W(XW), .F(F)) u_div_s
        (.clk(clk), .en(en), .num(ns_reg), .den(ds_reg), .quot(s_q));
    cpot_fdiv #(.W(XW), .F(F)) u_div_t
        (.clk(clk), .en(en), .num(nt_reg), .den(dt_reg), .quot(t_q));

    // stage F+8: closest-point terms; the register behind them forms g = w + s*u - t*v
    logic signed [DW-1:0]    qu [0:2], qv [0:2], qw [0:2];
    logic signed [N+F+2:0]   su_reg [0:2], tv_reg [0:2];
    logic signed [DW+F-1:0]  ws_reg [0:2];
    logic signed [GW-1:0]    g_reg  [0:2];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            qu[a] = $signed(uvw_reg[UVD-1][a*DW +: DW]);
            qv[a] = $signed(uvw_reg[UVD-1][(3+a)*DW +: DW]);
            qw[a] = $signed(uvw_reg[UVD-1][(6+a)*DW +: DW]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                su_reg[a] <= $signed({1'b0, s_q}) * qu[a];
                tv_reg[a] <= $signed({1'b0, t_q}) * qv[a];
                ws_reg[a] <= (DW+F)'(qw[a]) <<< F;
                g_reg[a]  <= GW'(ws_reg[a]) + GW'(su_reg[a]) - GW'(tv_reg[a]);
            end
        end
    end

    // stages F+10 .. F+11: squares
    logic signed [SQW-1:0] sq [0:2];

    cpot_smul #(.AW(GW), .BW(GW)) u_sq0
        (.clk(clk), .en(en), .a(g_reg[0]), .b(g_reg[0]), .p(sq[0]));
    cpot_smul #(.AW(GW), .BW(GW)) u_sq1
        (.clk(clk), .en(en), .a(g_reg[1]), .b(g_reg[1]), .p(sq[1]));
    cpot_smul #(.AW(GW), .BW(GW)) u_sq2
        (.clk(clk), .en(en), .a(g_reg[2]), .b(g_reg[2]), .p(sq[2]));

    // stages F+12 .. F+13: sum, compare, saturate
    logic [SW-1:0]        sum_reg;
    logic [MW-1:0]        d_ext;
    logic                 ovl_reg;
    logic [DIST_BITS-1:0] dist_reg;

    assign d_ext = MW'(sum_reg >> (2 * F));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg  <= SW'($unsigned(sq[0])) + SW'($unsigned(sq[1]))
                      + SW'($unsigned(sq[2]));
            ovl_reg  <= sum_reg < SW'({rsq_reg[RQD-1], {(2*F){1'b0}}});
            dist_reg <= (d_ext > MW'(DIST_MAX)) ? DIST_MAX : d_ext[DIST_BITS-1:0];
        end
    end

    assign m_axis_tdata = {dist_reg, ovl_reg};

endmodule

// File: design/cpot_smul.sv
// ----------------------------------------------------------------------------
// cpot_smul
// Two-stage signed multiplier. The B operand is split in halves; the partial
// products are registered, then shifted and added.
// ----------------------------------------------------------------------------
module cpot_smul
#(
    parameter int AW = 44,
    parameter int BW = 44
)
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [AW-1:0]       a,
    input  logic signed [BW-1:0]       b,
    output logic signed [AW+BW-1:0]    p
);

    localparam int H  = BW / 2;
    localparam int PW = AW + BW;

    logic signed [AW+H:0]      lo_reg, lo_next;
    logic signed [AW+BW-H-1:0] hi_reg, hi_next;
    logic signed [PW-1:0]      p_reg, p_next;

    always_comb
    begin
        lo_next = a * $signed({1'b0, b[H-1:0]});
        hi_next = a * $signed(b[BW-1:H]);
        p_next  = (PW'(hi_reg) <<< H) + PW'(lo_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// File: design/cpot_fdiv.sv
// ----------------------------------------------------------------------------
// cpot_fdiv
// Pipelined fractional divider: num/den clamped to [0,1] with F fraction
// bits, one restoring step per stage. Zero denominator gives one for a
// non-negative numerator and zero otherwise.
// ----------------------------------------------------------------------------
module cpot_fdiv
#(
    parameter int W = 89,
    parameter int F = 16
)
(
    input  logic                clk,
    input  logic                en,
    input  logic signed [W-1:0] num,
    input  logic [W-1:0]        den,
    output logic [F:0]          quot
);

    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    logic         fix_reg [0:F];
    logic [F:0]   fq_reg  [0:F];
    logic [W-1:0] rem_reg [0:F];
    logic [W-1:0] dv_reg  [0:F];
    logic [F-1:0] q_reg   [0:F];

    logic         fix_next [0:F];
    logic [F:0]   fq_next  [0:F];
    logic [W-1:0] rem_next [0:F];
    logic [W-1:0] dv_next  [0:F];
    logic [F-1:0] q_next   [0:F];

    logic         neg;
    logic [W-1:0] mag;
    logic [W:0]   sh   [0:F-1];
    logic         ge   [0:F-1];

    always_comb
    begin
        neg = num[W-1];
        mag = neg ? (~num + 1'b1) : num;
        fix_next[0] = 1'b1;
        fq_next[0]  = '0;
        if (den == '0)
            fq_next[0] = neg ? '0 : ONE;
        else if (neg || mag == '0)
            fq_next[0] = '0;
        else if (mag >= den)
            fq_next[0] = ONE;
        else
            fix_next[0] = 1'b0;
        rem_next[0] = mag;
        dv_next[0]  = den;
        q_next[0]   = '0;

        for (int k = 0; k < F; k++)
        begin
            sh[k] = {rem_reg[k], 1'b0};
            ge[k] = sh[k] >= {1'b0, dv_reg[k]};
            rem_next[k+1] = ge[k] ? W'(sh[k] - {1'b0, dv_reg[k]}) : W'(sh[k]);
            q_next[k+1]   = {q_reg[k][F-2:0], ge[k]};
            fix_next[k+1] = fix_reg[k];
            fq_next[k+1]  = fq_reg[k];
            dv_next[k+1]  = dv_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= F; k++)
            begin
                fix_reg[k] <= fix_next[k];
                fq_reg[k]  <= fq_next[k];
                rem_reg[k] <= rem_next[k];
                dv_reg[k]  <= dv_next[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    assign quot = fix_reg[F] ? fq_reg[F] : {1'b0, q_reg[F]};

endmodule
